>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/tbpm_pkg.sv
// Types and constants of the tilt and button pad mapper.
// No dependencies; used by every module of the block.
package tbpm_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_DBL_WIN,
        REG_START_LEN,
        REG_SEL_HOLD,
        REG_DEAD_ZONE,
        REG_SIDE_LIM,
        REG_DOWN_LIM,
        REG_UP_LIM,
        REG_BACK_LIM
    } t_reg_idx;

    localparam logic [15:0] RST_DBL_WIN   = 16'd350;
    localparam logic [15:0] RST_START_LEN = 16'd300;
    localparam logic [15:0] RST_SEL_HOLD  = 16'd500;
    localparam logic [14:0] RST_DEAD_ZONE = 15'd205;
    localparam logic [14:0] RST_SIDE_LIM  = 15'd410;
    localparam logic [14:0] RST_DOWN_LIM  = 15'd614;
    localparam logic [14:0] RST_UP_LIM    = 15'd1024;
    localparam logic [14:0] RST_BACK_LIM  = 15'd1024;

    // pad bit positions (active low)
    localparam int PAD_UP     = 0;
    localparam int PAD_DOWN   = 1;
    localparam int PAD_LEFT   = 2;
    localparam int PAD_RIGHT  = 3;
    localparam int PAD_SELECT = 4;
    localparam int PAD_START  = 5;
    localparam int PAD_A      = 6;
    localparam int PAD_B      = 7;

    typedef struct packed {
        logic [15:0] dbl_win;
        logic [15:0] start_len;
        logic [15:0] sel_hold;
        logic [14:0] dead_zone;
        logic [14:0] side_lim;
        logic [14:0] down_lim;
        logic [14:0] up_lim;
        logic [14:0] back_lim;
    } t_cfg;

    typedef struct packed {
        logic [31:0]        time_ms;
        logic               button_a;
        logic               button_b;
        logic               button_b_edge;
        logic               accel_valid;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
    } t_item;

    // upper pad nibble, bit 7 down to bit 4
    typedef struct packed {
        logic b_n;
        logic a_n;
        logic start_n;
        logic select_n;
    } t_btn_pad;

    // lower pad nibble, bit 3 down to bit 0
    typedef struct packed {
        logic right_n;
        logic left_n;
        logic down_n;
        logic up_n;
    } t_dir_pad;

endpackage

>>> hw/rtl/tbpm_regs.sv
// Configuration register file on the APB-style port.
// Depends on tbpm_pkg.
module tbpm_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tbpm_pkg::ADDR_W-1:0] paddr,
    input  logic [tbpm_pkg::DATA_W-1:0] pwdata,
    output logic [tbpm_pkg::DATA_W-1:0] prdata,
    output tbpm_pkg::t_cfg              o_cfg
);

    tbpm_pkg::t_cfg   r_cfg;
    tbpm_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx = tbpm_pkg::t_reg_idx'(paddr[tbpm_pkg::ADDR_W-1:2]);
    assign w_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dbl_win   <= tbpm_pkg::RST_DBL_WIN;
            r_cfg.start_len <= tbpm_pkg::RST_START_LEN;
            r_cfg.sel_hold  <= tbpm_pkg::RST_SEL_HOLD;
            r_cfg.dead_zone <= tbpm_pkg::RST_DEAD_ZONE;
            r_cfg.side_lim  <= tbpm_pkg::RST_SIDE_LIM;
            r_cfg.down_lim  <= tbpm_pkg::RST_DOWN_LIM;
            r_cfg.up_lim    <= tbpm_pkg::RST_UP_LIM;
            r_cfg.back_lim  <= tbpm_pkg::RST_BACK_LIM;
        end else if (w_wr) begin
            case (w_idx)
                tbpm_pkg::REG_DBL_WIN:   r_cfg.dbl_win   <= pwdata[15:0];
                tbpm_pkg::REG_START_LEN: r_cfg.start_len <= pwdata[15:0];
                tbpm_pkg::REG_SEL_HOLD:  r_cfg.sel_hold  <= pwdata[15:0];
                tbpm_pkg::REG_DEAD_ZONE: r_cfg.dead_zone <= pwdata[14:0];
                tbpm_pkg::REG_SIDE_LIM:  r_cfg.side_lim  <= pwdata[14:0];
                tbpm_pkg::REG_DOWN_LIM:  r_cfg.down_lim  <= pwdata[14:0];
                tbpm_pkg::REG_UP_LIM:    r_cfg.up_lim    <= pwdata[14:0];
                tbpm_pkg::REG_BACK_LIM:  r_cfg.back_lim  <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            tbpm_pkg::REG_DBL_WIN:   prdata = 32'(r_cfg.dbl_win);
            tbpm_pkg::REG_START_LEN: prdata = 32'(r_cfg.start_len);
            tbpm_pkg::REG_SEL_HOLD:  prdata = 32'(r_cfg.sel_hold);
            tbpm_pkg::REG_DEAD_ZONE: prdata = 32'(r_cfg.dead_zone);
            tbpm_pkg::REG_SIDE_LIM:  prdata = 32'(r_cfg.side_lim);
            tbpm_pkg::REG_DOWN_LIM:  prdata = 32'(r_cfg.down_lim);
            tbpm_pkg::REG_UP_LIM:    prdata = 32'(r_cfg.up_lim);
            tbpm_pkg::REG_BACK_LIM:  prdata = 32'(r_cfg.back_lim);
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/tbpm_btn.sv
// Button timing: double-press START pulse, SELECT/B hold split, A mapping.
// Depends on tbpm_pkg.
module tbpm_btn (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  tbpm_pkg::t_item    i_item,
    input  tbpm_pkg::t_cfg     i_cfg,
    output tbpm_pkg::t_btn_pad o_pad
);

    logic [31:0] r_last, r_hold, r_end;
    logic        r_pulse;
    logic [31:0] n_last, n_hold, n_end;
    logic        n_pulse;

    logic [31:0] w_now, w_press_dt, w_end_dt, w_hold_dt;
    logic        w_hit, w_pulse_live, w_held;

    assign w_now      = i_item.time_ms;
    assign w_press_dt = w_now - r_last;
    assign w_hit      = i_item.button_b_edge && (w_press_dt < 32'(i_cfg.dbl_win));

    always_comb begin
        n_last = r_last;
        n_hold = r_hold;
        n_end  = r_end;
        if (w_hit) begin
            n_end  = w_now + 32'(i_cfg.start_len);
            n_last = '0;
        end else if (i_item.button_b_edge) begin
            n_last = w_now;
            n_hold = w_now;
        end
    end

    assign w_pulse_live = w_hit || r_pulse;
    assign w_end_dt     = w_now - n_end;
    assign w_hold_dt    = w_now - n_hold;
    assign w_held       = w_hold_dt > 32'(i_cfg.sel_hold);
    // pulse keeps running while now is still before the wrap-safe end time
    assign n_pulse      = w_pulse_live && w_end_dt[31];

    always_comb begin
        o_pad = '1;
        if (w_pulse_live) begin
            o_pad.start_n = !w_end_dt[31];
        end else begin
            o_pad.a_n      = !i_item.button_a;
            o_pad.select_n = !(i_item.button_b && w_held);
            o_pad.b_n      = !(i_item.button_b && !w_held);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_hold  <= '0;
            r_end   <= '0;
            r_pulse <= 1'b0;
        end else if (i_en) begin
            r_last  <= n_last;
            r_hold  <= n_hold;
            r_end   <= n_end;
            r_pulse <= n_pulse;
        end
    end

endmodule

>>> hw/rtl/tbpm_tilt.sv
// Accelerometer baseline averaging and tilt-to-direction mapping.
// Depends on tbpm_pkg.
module tbpm_tilt #(
    parameter int CAL_SAMPLES = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  tbpm_pkg::t_item    i_item,
    input  tbpm_pkg::t_cfg     i_cfg,
    output tbpm_pkg::t_dir_pad o_pad,
    output logic               o_cal_done
);

    localparam int CNT_W     = $clog2(CAL_SAMPLES + 1);
    localparam int LOG_N     = $clog2(CAL_SAMPLES);
    localparam int SUM_W     = 16 + LOG_N;
    localparam int DIV_SHIFT = SUM_W + LOG_N;
    localparam int RECIP_W   = SUM_W + 2;
    localparam int PROD_W    = SUM_W + RECIP_W;
    // bias makes the sum non-negative and adds half a divisor for rounding
    localparam int CAL_OFS   = 32768 * CAL_SAMPLES + CAL_SAMPLES / 2;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << DIV_SHIFT) + 64'(CAL_SAMPLES - 1)) / 64'(CAL_SAMPLES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    logic                    r_cal;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [SUM_W-1:0] r_sum_x, r_sum_y;
    logic signed [15:0]      r_base_x, r_base_y;

    logic [CNT_W-1:0]        n_cnt;
    logic signed [SUM_W-1:0] n_sum_x, n_sum_y;
    logic signed [15:0]      n_base_x, n_base_y;
    logic                    w_cal_step, w_last;

    // rounded mean: floor((sum + bias) / N) via exact reciprocal multiply
    function automatic logic signed [15:0] mean_of(input logic signed [SUM_W-1:0] sum);
        logic [SUM_W:0]    wide;
        logic [PROD_W-1:0] prod;
        logic [15:0]       quot;
        wide = {sum[SUM_W-1], sum} + (SUM_W + 1)'(CAL_OFS);
        prod = PROD_W'(wide[SUM_W-1:0]) * PROD_W'(RECIP);
        quot = prod[DIV_SHIFT +: 16];
        return $signed({~quot[15], quot[14:0]});
    endfunction

    function automatic logic signed [17:0] dead_band(input logic signed [16:0] d,
                                                     input logic [14:0] zone);
        logic [16:0] mag;
        mag = d[16] ? 17'(-d) : 17'(d);
        return (mag < 17'(zone)) ? 18'sd0 : {d[16], d};
    endfunction

    assign w_cal_step = i_item.accel_valid && !r_cal;
    assign n_cnt      = r_cnt + CNT_W'(1);
    assign w_last     = n_cnt == CNT_W'(CAL_SAMPLES);
    assign n_sum_x    = r_sum_x + SUM_W'(i_item.accel_x);
    assign n_sum_y    = r_sum_y + SUM_W'(i_item.accel_y);
    assign n_base_x   = mean_of(n_sum_x);
    assign n_base_y   = mean_of(n_sum_y);
    assign o_cal_done = r_cal || (w_cal_step && w_last);

    logic signed [16:0] w_dx_raw, w_dy_raw;
    logic signed [17:0] w_dx, w_dy;
    logic signed [17:0] w_side, w_down, w_up, w_back;

    assign w_dx_raw = 17'(i_item.accel_x) - 17'(r_base_x);
    assign w_dy_raw = 17'(i_item.accel_y) - 17'(r_base_y);
    assign w_dx     = dead_band(w_dx_raw, i_cfg.dead_zone);
    assign w_dy     = dead_band(w_dy_raw, i_cfg.dead_zone);
    assign w_side   = $signed({3'b000, i_cfg.side_lim});
    assign w_down   = $signed({3'b000, i_cfg.down_lim});
    assign w_up     = $signed({3'b000, i_cfg.up_lim});
    assign w_back   = $signed({3'b000, i_cfg.back_lim});

    always_comb begin
        o_pad = '1;
        if (i_item.accel_valid && r_cal) begin
            if (w_dx < -w_side) begin
                o_pad.right_n = 1'b0;
            end else if (w_dx > w_side) begin
                o_pad.left_n = 1'b0;
            end
            o_pad.down_n = !(w_dy > w_down);
            o_pad.up_n   = !((w_dy < -w_up) || (w_dx > w_back));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal    <= 1'b0;
            r_cnt    <= '0;
            r_sum_x  <= '0;
            r_sum_y  <= '0;
            r_base_x <= '0;
            r_base_y <= '0;
        end else if (i_en && w_cal_step) begin
            r_cnt   <= n_cnt;
            r_sum_x <= n_sum_x;
            r_sum_y <= n_sum_y;
            if (w_last) begin
                r_base_x <= n_base_x;
                r_base_y <= n_base_y;
                r_cal    <= 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/tilt_and_button_pad_mapper.sv
// Top level of the tilt and button pad mapper: handshake registers and assertions.
// Depends on tbpm_pkg, tbpm_regs, tbpm_btn, tbpm_tilt and assert_macros.svh.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | sink      | i_in_valid / o_in_ready   | time, buttons, B edge, accel sample
//  out     | source    | o_out_valid / i_out_ready | pad_bits, calibrated_flag
//  cfg     | APB slave | psel, penable, pready     | paddr, pwdata, prdata
//
// One poll transfer per cycle, sustained while i_out_ready takes each result. A transfer
// lands in the input register, its result is formed from that register and moves
// into the output register once that register is free or being emptied.
// Reset is synchronous and active low; it restores register defaults and clears all
// timing and calibration state. No clearing pass follows.
// When the result register is full and not taken, the input register holds and
// o_in_ready drops only once both registers are occupied.
`include "assert_macros.svh"

module tilt_and_button_pad_mapper #(
    parameter int CAL_SAMPLES = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tbpm_pkg::ADDR_W-1:0] paddr,
    input  logic [tbpm_pkg::DATA_W-1:0] pwdata,
    output logic [tbpm_pkg::DATA_W-1:0] prdata,
    output logic                        pready,

    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [31:0]                 i_time_ms,
    input  logic                        i_button_a,
    input  logic                        i_button_b,
    input  logic                        i_button_b_edge,
    input  logic                        i_accel_valid,
    input  logic signed [15:0]          i_accel_x,
    input  logic signed [15:0]          i_accel_y,

    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [7:0]                  o_pad_bits,
    output logic                        o_calibrated_flag
);

    tbpm_pkg::t_cfg     w_cfg;
    tbpm_pkg::t_item    r_item;
    tbpm_pkg::t_btn_pad w_btn_pad;
    tbpm_pkg::t_dir_pad w_dir_pad;
    logic               w_cal_done;

    logic       r_in_valid, r_out_valid;
    logic [7:0] r_pad;
    logic       r_cal_flag;
    logic       w_advance;
    logic       w_start_on, w_btn_quiet, w_b_or_sel, w_dir_quiet;

    assign pready = 1'b1;

    tbpm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    // the held item moves into the result register when that register is free
    // or being emptied in the same cycle
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.time_ms       <= i_time_ms;
            r_item.button_a      <= i_button_a;
            r_item.button_b      <= i_button_b;
            r_item.button_b_edge <= i_button_b_edge;
            r_item.accel_valid   <= i_accel_valid;
            r_item.accel_x       <= i_accel_x;
            r_item.accel_y       <= i_accel_y;
        end
        if (w_advance) begin
            r_pad      <= {w_btn_pad, w_dir_pad};
            r_cal_flag <= w_cal_done;
        end
    end

    // button and tilt state both advance only when the item commits
    tbpm_btn u_btn (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_advance),
        .i_item  (r_item),
        .i_cfg   (w_cfg),
        .o_pad   (w_btn_pad)
    );

    tbpm_tilt #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_tilt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_advance),
        .i_item     (r_item),
        .i_cfg      (w_cfg),
        .o_pad      (w_dir_pad),
        .o_cal_done (w_cal_done)
    );

    assign o_out_valid       = r_out_valid;
    assign o_pad_bits        = r_pad;
    assign o_calibrated_flag = r_cal_flag;

    // pad flags checked below
    assign w_start_on  = !o_pad_bits[tbpm_pkg::PAD_START];
    assign w_btn_quiet = o_pad_bits[tbpm_pkg::PAD_A] && o_pad_bits[tbpm_pkg::PAD_B]
                         && o_pad_bits[tbpm_pkg::PAD_SELECT];
    assign w_b_or_sel  = o_pad_bits[tbpm_pkg::PAD_B] || o_pad_bits[tbpm_pkg::PAD_SELECT];
    assign w_dir_quiet = o_pad_bits[tbpm_pkg::PAD_UP] && o_pad_bits[tbpm_pkg::PAD_DOWN]
                         && o_pad_bits[tbpm_pkg::PAD_LEFT] && o_pad_bits[tbpm_pkg::PAD_RIGHT];

    // a running START pulse masks A, B and SELECT
    `ASSERT_IMPL(a_start_masks, i_clk, i_rst_n, o_out_valid && w_start_on, w_btn_quiet)
    // B hold reports either SELECT or B, never both
    `ASSERT_IMPL(a_sel_or_b, i_clk, i_rst_n, o_out_valid, w_b_or_sel)
    // no direction bits before the baseline exists
    `ASSERT_IMPL(a_no_tilt_uncal, i_clk, i_rst_n, o_out_valid && !o_calibrated_flag, w_dir_quiet)
    // calibration, once reached, is reported on every later result
    `ASSERT_NEXT(a_cal_sticky, i_clk, i_rst_n, w_advance && w_cal_done, r_cal_flag && w_cal_done)

endmodule
